### hdl/s5hp_pkg.sv
package s5hp_pkg;

	typedef enum logic [2:0] {
		EV_CONSUMED = 3'd0,
		EV_GREETED  = 3'd1,
		EV_ACC_V4   = 3'd2,
		EV_ACC_DOM  = 3'd3,
		EV_REJECT   = 3'd4,
		EV_BAD_ATYP = 3'd5,
		EV_IGNORED  = 3'd6
	} event_t;

	localparam logic [7:0] SOCKS_VER   = 8'h05;
	localparam logic [7:0] CMD_CONNECT = 8'h01;
	localparam logic [7:0] ATYP_IPV4   = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN = 8'h03;
	localparam logic [7:0] ATYP_IPV6   = 8'h04;
	localparam logic [7:0] V4_LEN      = 8'd4;
	localparam logic [7:0] V6_LEN      = 8'd16;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  name_byte;
		logic        name_byte_valid;
		logic [7:0]  name_index;
		logic [31:0] target_ipv4;
		logic [15:0] target_port;
		logic [7:0]  name_length;
	} res_t;

endpackage

### hdl/s5hp_if.sv
interface s5hp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_connection;

	modport source(output valid, output data_byte, output new_connection, input ready);
	modport sink(input valid, input data_byte, input new_connection, output ready);
endinterface

interface s5hp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  name_byte;
	logic        name_byte_valid;
	logic [7:0]  name_index;
	logic [31:0] target_ipv4;
	logic [15:0] target_port;
	logic [7:0]  name_length;

	modport source(output valid, output event_res, output name_byte, output name_byte_valid,
		output name_index, output target_ipv4, output target_port, output name_length,
		input ready);
	modport sink(input valid, input event_res, input name_byte, input name_byte_valid,
		input name_index, input target_ipv4, input target_port, input name_length,
		output ready);
endinterface

### hdl/socks5_handshake_parser.sv
// SOCKS5 client-side handshake parser. Takes the client stream one byte per beat on
// stream and returns exactly one result beat on result for every byte: consumed,
// greeting done (reply 05 00 due), accept IPv4, accept domain, rejected, bad address
// type, or ignored. Domain name bytes come out with their index; the IPv4 address,
// port and name length are shown only with the outcome that carries them and are
// zero otherwise. Raising new_connection with a byte restarts parsing at the
// greeting before that byte is taken. After an accept, a reject or a bad address
// type every byte is reported as ignored until a new connection starts. Throughput
// is one byte per clock while the result queue has room; a byte waits in the input
// register until the two-entry result queue has room, and its result is available
// from the queue on the following cycle after it is written. The per-byte state
// update is the single step between the input register and the result queue.
module socks5_handshake_parser import s5hp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	s5hp_byte_if.sink     stream,
	s5hp_res_if.source    result
);

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       newconn_s1;

	logic       fifo_space;
	logic       advance;
	res_t       step_res;
	res_t       out_res;

	// the byte in the input register steps the parser when the queue has room
	assign advance      = valid_s1 && fifo_space;
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_s1    <= stream.data_byte;
			newconn_s1 <= stream.new_connection;
		end
	end

	// parser state and per-byte result
	s5hp_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (advance),
		.data_byte      (data_s1),
		.new_connection (newconn_s1),
		.res            (step_res)
	);

	// result queue decouples result.ready from stream.ready
	s5hp_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance),
		.wr_data   (step_res),
		.has_space (fifo_space),
		.rd_valid  (result.valid),
		.rd_en     (result.valid && result.ready),
		.rd_data   (out_res)
	);

	assign result.event_res       = out_res.event_res;
	assign result.name_byte       = out_res.name_byte;
	assign result.name_byte_valid = out_res.name_byte_valid;
	assign result.name_index      = out_res.name_index;
	assign result.target_ipv4     = out_res.target_ipv4;
	assign result.target_port     = out_res.target_port;
	assign result.name_length     = out_res.name_length;

endmodule

### hdl/s5hp_parse.sv
module s5hp_parse import s5hp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] data_byte,
	input  logic       new_connection,
	output res_t       res
);

	typedef enum logic [3:0] {
		G_VER   = 4'd0,
		G_NMETH = 4'd1,
		G_METH  = 4'd2,
		R_VER   = 4'd3,
		R_CMD   = 4'd4,
		R_RSV   = 4'd5,
		R_ATYP  = 4'd6,
		R_V4    = 4'd7,
		R_V6    = 4'd8,
		R_DLEN  = 4'd9,
		R_DOM   = 4'd10,
		R_PHI   = 4'd11,
		R_PLO   = 4'd12,
		DONE    = 4'd13
	} step_t;

	step_t       step_q, cur_step, nxt_step;
	logic [7:0]  req_ver_q, cur_req_ver, nxt_req_ver;
	logic [7:0]  req_cmd_q, cur_req_cmd, nxt_req_cmd;
	logic [7:0]  atyp_q, cur_atyp, nxt_atyp;
	logic [7:0]  alen_q, cur_alen, nxt_alen;
	logic [7:0]  acnt_q, cur_acnt, nxt_acnt;
	logic [31:0] ipv4_q, cur_ipv4, nxt_ipv4;
	logic [7:0]  port_hi_q, cur_port_hi, nxt_port_hi;
	logic [7:0]  mtot_q, cur_mtot, nxt_mtot;
	logic [7:0]  mcnt_q, cur_mcnt, nxt_mcnt;
	logic [7:0]  acnt_inc, mcnt_inc;
	logic        req_ok;

	// new connection restarts from the reset state before this beat
	always_comb begin
		cur_step    = new_connection ? G_VER : step_q;
		cur_req_ver = new_connection ? 8'd0 : req_ver_q;
		cur_req_cmd = new_connection ? 8'd0 : req_cmd_q;
		cur_atyp    = new_connection ? 8'd0 : atyp_q;
		cur_alen    = new_connection ? 8'd0 : alen_q;
		cur_acnt    = new_connection ? 8'd0 : acnt_q;
		cur_ipv4    = new_connection ? 32'd0 : ipv4_q;
		cur_port_hi = new_connection ? 8'd0 : port_hi_q;
		cur_mtot    = new_connection ? 8'd0 : mtot_q;
		cur_mcnt    = new_connection ? 8'd0 : mcnt_q;
	end

	assign acnt_inc = cur_acnt + 8'd1;
	assign mcnt_inc = cur_mcnt + 8'd1;
	assign req_ok   = (cur_req_ver == SOCKS_VER) && (cur_req_cmd == CMD_CONNECT);

	always_comb begin
		nxt_step    = cur_step;
		nxt_req_ver = cur_req_ver;
		nxt_req_cmd = cur_req_cmd;
		nxt_atyp    = cur_atyp;
		nxt_alen    = cur_alen;
		nxt_acnt    = cur_acnt;
		nxt_ipv4    = cur_ipv4;
		nxt_port_hi = cur_port_hi;
		nxt_mtot    = cur_mtot;
		nxt_mcnt    = cur_mcnt;
		res         = '0;
		res.event_res = EV_CONSUMED;

		unique case (cur_step)
			G_VER: begin
				nxt_step = G_NMETH;
			end
			G_NMETH: begin
				nxt_mtot = data_byte;
				nxt_mcnt = 8'd0;
				if (data_byte == 8'd0) begin
					res.event_res = EV_GREETED;
					nxt_step = R_VER;
				end else begin
					nxt_step = G_METH;
				end
			end
			G_METH: begin
				nxt_mcnt = mcnt_inc;
				if (mcnt_inc == cur_mtot) begin
					res.event_res = EV_GREETED;
					nxt_step = R_VER;
				end
			end
			R_VER: begin
				nxt_req_ver = data_byte;
				nxt_step = R_CMD;
			end
			R_CMD: begin
				nxt_req_cmd = data_byte;
				nxt_step = R_RSV;
			end
			R_RSV: begin
				nxt_step = R_ATYP;
			end
			R_ATYP: begin
				nxt_atyp = data_byte;
				nxt_acnt = 8'd0;
				nxt_ipv4 = 32'd0;
				if (data_byte == ATYP_IPV4) begin
					nxt_alen = V4_LEN;
					nxt_step = R_V4;
				end else if (data_byte == ATYP_IPV6) begin
					nxt_alen = V6_LEN;
					nxt_step = R_V6;
				end else if (data_byte == ATYP_DOMAIN) begin
					nxt_alen = 8'd0;
					nxt_step = R_DLEN;
				end else begin
					res.event_res = EV_BAD_ATYP;
					nxt_step = DONE;
				end
			end
			R_V4: begin
				nxt_ipv4 = {cur_ipv4[23:0], data_byte};
				nxt_acnt = acnt_inc;
				if (acnt_inc >= V4_LEN) nxt_step = R_PHI;
			end
			R_V6: begin
				nxt_acnt = acnt_inc;
				if (acnt_inc >= V6_LEN) nxt_step = R_PHI;
			end
			R_DLEN: begin
				nxt_alen = data_byte;
				nxt_acnt = 8'd0;
				nxt_step = (data_byte == 8'd0) ? R_PHI : R_DOM;
			end
			R_DOM: begin
				res.name_byte       = data_byte;
				res.name_byte_valid = 1'b1;
				res.name_index      = cur_acnt;
				nxt_acnt = acnt_inc;
				if (acnt_inc == cur_alen) nxt_step = R_PHI;
			end
			R_PHI: begin
				nxt_port_hi = data_byte;
				nxt_step = R_PLO;
			end
			R_PLO: begin
				res.target_port = {cur_port_hi, data_byte};
				if (req_ok && cur_atyp == ATYP_IPV4) begin
					res.event_res   = EV_ACC_V4;
					res.target_ipv4 = cur_ipv4;
				end else if (req_ok && cur_atyp == ATYP_DOMAIN) begin
					res.event_res   = EV_ACC_DOM;
					res.name_length = cur_alen;
				end else begin
					res.event_res = EV_REJECT;
				end
				nxt_step = DONE;
			end
			default: begin
				res.event_res = EV_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= G_VER;
			req_ver_q <= '0;
			req_cmd_q <= '0;
			atyp_q    <= '0;
			alen_q    <= '0;
			acnt_q    <= '0;
			ipv4_q    <= '0;
			port_hi_q <= '0;
			mtot_q    <= '0;
			mcnt_q    <= '0;
		end else if (step_en) begin
			step_q    <= nxt_step;
			req_ver_q <= nxt_req_ver;
			req_cmd_q <= nxt_req_cmd;
			atyp_q    <= nxt_atyp;
			alen_q    <= nxt_alen;
			acnt_q    <= nxt_acnt;
			ipv4_q    <= nxt_ipv4;
			port_hi_q <= nxt_port_hi;
			mtot_q    <= nxt_mtot;
			mcnt_q    <= nxt_mcnt;
		end
	end

endmodule

### hdl/s5hp_res_fifo.sv
module s5hp_res_fifo import s5hp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  res_t wr_data,
	output logic has_space,
	output logic rd_valid,
	input  logic rd_en,
	output res_t rd_data
);

	res_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign has_space = (cnt_q != 2'd2);
	assign rd_valid  = (cnt_q != 2'd0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en)      cnt_q <= cnt_q + 2'd1;
			else if (!wr_en && rd_en) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

### hdl/s5hp_checker.sv
module s5hp_checker import s5hp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  event_res,
	input logic        name_byte_valid,
	input logic [31:0] target_ipv4,
	input logic [15:0] target_port
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// name bytes only travel on plain consumed beats
	a_name_evt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && name_byte_valid |-> event_res == EV_CONSUMED)
		else $error("name byte on an outcome beat");

	// address shown only on IPv4 accept
	a_ipv4_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res != EV_ACC_V4 |-> target_ipv4 == 32'd0)
		else $error("target_ipv4 set outside IPv4 accept");

	// port shown only at the end of a request
	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res != EV_ACC_V4 && event_res != EV_ACC_DOM
		&& event_res != EV_REJECT |-> target_port == 16'd0)
		else $error("target_port set outside request outcome");

endmodule

bind socks5_handshake_parser s5hp_checker u_s5hp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.event_res       (result.event_res),
	.name_byte_valid (result.name_byte_valid),
	.target_ipv4     (result.target_ipv4),
	.target_port     (result.target_port)
);

### bench/socks5_handshake_parser_tb.sv
module socks5_handshake_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import s5hp_pkg::*;

	// Nothing accepted on either side for this many cycles means the block hung
	localparam int STALL_LIMIT  = 2000;
	// Results pass the input register and the result queue; slack after the last beat
	localparam int SETTLE_BEATS = 8;

	// Parser position, mirrors the block's step encoding
	typedef enum logic [3:0] {
		PS_G_VER, PS_G_NMETH, PS_G_METH,
		PS_R_VER, PS_R_CMD, PS_R_RSV, PS_R_ATYP,
		PS_R_V4, PS_R_V6, PS_R_DLEN, PS_R_DOM,
		PS_R_PHI, PS_R_PLO, PS_DONE
	} parse_step_t;

	logic clk = 1'b0;
	logic arst_n;

	s5hp_byte_if stream_if();
	s5hp_res_if  result_if();

	socks5_handshake_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	always #5 clk = ~clk;

	// Shadow of the parser state, advanced once per accepted beat
	parse_step_t step;
	logic [7:0]  req_ver;
	logic [7:0]  req_cmd;
	logic [7:0]  addr_type;
	logic [7:0]  addr_len;
	logic [7:0]  addr_cnt;
	logic [31:0] ipv4_acc;
	logic [7:0]  port_hi;
	logic [7:0]  meth_total;
	logic [7:0]  meth_cnt;

	res_t        pending_results[$];
	res_t        want;
	int          errors;
	int          beats_fed;    // accepted beats that the parser did not ignore
	int          stall_cycles;
	bit          steady;       // when set, neither side inserts bubbles

	function automatic void clear_session();
		step       = PS_G_VER;
		req_ver    = '0;
		req_cmd    = '0;
		addr_type  = '0;
		addr_len   = '0;
		addr_cnt   = '0;
		ipv4_acc   = '0;
		port_hi    = '0;
		meth_total = '0;
		meth_cnt   = '0;
	endfunction

	// Work out the one result beat a client byte causes and advance the shadow state.
	// new_connection restarts at the greeting before the byte itself is parsed.
	function automatic res_t predict_beat(input logic [7:0] b, input logic nc);
		res_t r;
		r = '0;
		r.event_res = EV_CONSUMED;
		if (nc) clear_session();
		case (step)
		PS_G_VER: step = PS_G_NMETH;   // greeting version is never checked
		PS_G_NMETH: begin
			meth_total = b;
			meth_cnt   = '0;
			// empty method list closes the greeting on the count byte
			if (b == 8'd0) begin
				r.event_res = EV_GREETED;
				step = PS_R_VER;
			end else begin
				step = PS_G_METH;
			end
		end
		PS_G_METH: begin
			meth_cnt = meth_cnt + 8'd1;
			if (meth_cnt == meth_total) begin
				r.event_res = EV_GREETED;
				step = PS_R_VER;
			end
		end
		PS_R_VER: begin
			req_ver = b;
			step = PS_R_CMD;
		end
		PS_R_CMD: begin
			req_cmd = b;
			step = PS_R_RSV;
		end
		PS_R_RSV: step = PS_R_ATYP;    // reserved byte, taken blind
		PS_R_ATYP: begin
			addr_type = b;
			addr_cnt  = '0;
			ipv4_acc  = '0;
			if (b == ATYP_IPV4) begin
				addr_len = V4_LEN;
				step = PS_R_V4;
			end else if (b == ATYP_IPV6) begin
				addr_len = V6_LEN;
				step = PS_R_V6;
			end else if (b == ATYP_DOMAIN) begin
				addr_len = '0;
				step = PS_R_DLEN;
			end else begin
				// unknown type: reported right away, session is over
				r.event_res = EV_BAD_ATYP;
				step = PS_DONE;
			end
		end
		PS_R_V4: begin
			ipv4_acc = {ipv4_acc[23:0], b};
			addr_cnt = addr_cnt + 8'd1;
			if (addr_cnt >= V4_LEN) step = PS_R_PHI;
		end
		PS_R_V6: begin
			addr_cnt = addr_cnt + 8'd1;
			if (addr_cnt >= V6_LEN) step = PS_R_PHI;
		end
		PS_R_DLEN: begin
			addr_len = b;
			addr_cnt = '0;
			// zero-length name goes straight to the port
			step = (b == 8'd0) ? PS_R_PHI : PS_R_DOM;
		end
		PS_R_DOM: begin
			r.name_byte       = b;
			r.name_byte_valid = 1'b1;
			r.name_index      = addr_cnt;
			addr_cnt = addr_cnt + 8'd1;
			if (addr_cnt == addr_len) step = PS_R_PHI;
		end
		PS_R_PHI: begin
			port_hi = b;
			step = PS_R_PLO;
		end
		PS_R_PLO: begin
			r.target_port = {port_hi, b};
			if (req_ver == SOCKS_VER && req_cmd == CMD_CONNECT && addr_type == ATYP_IPV4) begin
				r.event_res   = EV_ACC_V4;
				r.target_ipv4 = ipv4_acc;
			end else if (req_ver == SOCKS_VER && req_cmd == CMD_CONNECT &&
					addr_type == ATYP_DOMAIN) begin
				r.event_res   = EV_ACC_DOM;
				r.name_length = addr_len;
			end else begin
				// IPv6, wrong version or wrong command all land here
				r.event_res = EV_REJECT;
			end
			step = PS_DONE;
		end
		default: r.event_res = EV_IGNORED;   // after an outcome, and unused codes
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, got_val);
			errors++;
		end
	endfunction

	// Result side: every accepted result beat is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, expected none, got event %0d",
					$time, result_if.event_res);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("event_res", 32'(want.event_res), 32'(result_if.event_res));
				check_field("name_byte", 32'(want.name_byte), 32'(result_if.name_byte));
				check_field("name_byte_valid", 32'(want.name_byte_valid),
					32'(result_if.name_byte_valid));
				check_field("name_index", 32'(want.name_index), 32'(result_if.name_index));
				check_field("target_ipv4", want.target_ipv4, result_if.target_ipv4);
				check_field("target_port", 32'(want.target_port), 32'(result_if.target_port));
				check_field("name_length", 32'(want.name_length), 32'(result_if.name_length));
			end
		end
	end

	// Result backpressure: ready drops at random with a 7 percent chance unless steady
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_if.ready <= steady || ($urandom_range(0, 99) >= 7);
		end
	end

	// Hang detector: counts cycles with no beat accepted on either side
	always @(posedge clk) begin
		if (!arst_n || (stream_if.valid && stream_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// One client byte. valid is left high after the beat so back-to-back bytes
	// stream without a bubble; random gaps are inserted in front of the beat.
	task automatic send_beat(input logic [7:0] b, input logic nc);
		while (!steady && $urandom_range(0, 99) < 7) begin
			stream_if.valid <= 1'b0;
			@(posedge clk);
		end
		stream_if.valid          <= 1'b1;
		stream_if.data_byte      <= b;
		stream_if.new_connection <= nc;
		do @(posedge clk); while (!stream_if.ready);
		pending_results.push_back(predict_beat(b, nc));
		if (pending_results[$].event_res != EV_IGNORED) beats_fed++;
	endtask

	// Stop sending and hold off until every predicted result has come back
	task automatic wait_drained();
		stream_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_BEATS) @(posedge clk);
	endtask

	// Full client exchange: greeting with nmeth random methods, then the request.
	// The first byte raises new_connection. Address bytes are random; an unknown
	// address type ends the sequence at the ATYP byte.
	task automatic send_session(input logic [7:0] nmeth, input logic [7:0] ver,
			input logic [7:0] cmd, input logic [7:0] atyp, input logic [7:0] dlen,
			input logic [15:0] port);
		send_beat(8'($urandom), 1'b1);
		send_beat(nmeth, 1'b0);
		for (int i = 0; i < nmeth; i++) send_beat(8'($urandom), 1'b0);
		send_beat(ver, 1'b0);
		send_beat(cmd, 1'b0);
		send_beat(8'($urandom), 1'b0);
		send_beat(atyp, 1'b0);
		case (atyp)
		ATYP_IPV4: repeat (V4_LEN) send_beat(8'($urandom), 1'b0);
		ATYP_IPV6: repeat (V6_LEN) send_beat(8'($urandom), 1'b0);
		ATYP_DOMAIN: begin
			send_beat(dlen, 1'b0);
			for (int i = 0; i < dlen; i++) send_beat(8'($urandom), 1'b0);
		end
		default: return;
		endcase
		send_beat(port[15:8], 1'b0);
		send_beat(port[7:0], 1'b0);
	endtask

	// Corner cases: empty method list, zero-length name, a trailing ignored byte,
	// one-method greeting into an IPv4 accept, and an unknown address type
	task automatic test_directed();
		send_session(8'd0, SOCKS_VER, CMD_CONNECT, ATYP_DOMAIN, 8'd0, 16'h0000);
		send_beat(8'hFF, 1'b0);
		send_session(8'd1, SOCKS_VER, CMD_CONNECT, ATYP_IPV4, 8'd0, 16'hFFFF);
		send_session(8'd0, SOCKS_VER, CMD_CONNECT, 8'hFF, 8'd0, 16'h0000);
	endtask

	// A 255-byte name, so name_index reaches 254
	task automatic test_long_fields();
		send_session(8'd2, SOCKS_VER, CMD_CONNECT, ATYP_DOMAIN, 8'hFF, 16'($urandom));
	endtask

	// Mostly well-formed exchanges with random content; the rest is raw noise
	// with new_connection popping up mid-stream. Runs until n non-ignored beats.
	task automatic test_random_sessions(input int n);
		int          stop_at;
		logic [7:0]  nmeth;
		logic [7:0]  ver;
		logic [7:0]  cmd;
		logic [7:0]  atyp;
		logic [7:0]  dlen;
		int          pick;
		stop_at = beats_fed + n;
		while (beats_fed < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 12))
					send_beat(8'($urandom), $urandom_range(0, 9) == 0);
			end else begin
				nmeth = ($urandom_range(0, 49) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
				ver   = ($urandom_range(0, 4) != 0) ? SOCKS_VER : 8'($urandom);
				cmd   = ($urandom_range(0, 4) != 0) ? CMD_CONNECT : 8'($urandom);
				dlen  = ($urandom_range(0, 29) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
				pick  = $urandom_range(0, 9);
				if (pick < 4)
					atyp = ATYP_IPV4;
				else if (pick < 7)
					atyp = ATYP_DOMAIN;
				else if (pick < 9)
					atyp = ATYP_IPV6;
				else
					atyp = 8'($urandom);
				send_session(nmeth, ver, cmd, atyp, dlen, 16'($urandom));
				// up to two stray bytes after the outcome
				repeat ($urandom_range(0, 2)) send_beat(8'($urandom), 1'b0);
			end
			if ($urandom_range(0, 19) == 0) wait_drained();
		end
	endtask

	// Same mix with every bubble removed on both sides
	task automatic test_no_gaps(input int n);
		steady = 1'b1;
		test_random_sessions(n);
		steady = 1'b0;
	endtask

	initial begin
		errors    = 0;
		beats_fed = 0;
		steady    = 1'b0;
		clear_session();
		arst_n                   <= 1'b0;
		stream_if.valid          <= 1'b0;
		stream_if.data_byte      <= '0;
		stream_if.new_connection <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		test_long_fields();
		wait_drained();
		test_random_sessions(80);
		test_no_gaps(60);
		test_random_sessions(60);

		wait_drained();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
hdl/s5hp_pkg.sv
hdl/s5hp_if.sv
hdl/s5hp_parse.sv
hdl/s5hp_res_fifo.sv
hdl/socks5_handshake_parser.sv
hdl/s5hp_checker.sv
bench/socks5_handshake_parser_tb.sv
